### hdl/pe_pkg.sv
// shared types and constants for the polynomial evaluator
// used by pe_regs, pe_step and polynomial_evaluator; depends on nothing
`default_nettype none

package pe_pkg;

    localparam int DATA_W         = 32;
    localparam int PROD_W         = 2 * DATA_W;
    localparam int DEG_W          = 3;
    localparam int IDX_W          = 4;
    localparam int NUM_COEFFS     = 7;
    localparam int DEF_MAX_DEGREE = 6;
    localparam int DEF_FRAC_BITS  = 16;

    localparam logic [DATA_W-1:0] S32_MAX = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic [DATA_W-1:0] S32_MIN = {1'b1, {(DATA_W-1){1'b0}}};

    typedef enum logic [IDX_W-1:0] {
        REG_DEGREE  = 4'd0,
        REG_COEFF_0 = 4'd1,
        REG_COEFF_1 = 4'd2,
        REG_COEFF_2 = 4'd3,
        REG_COEFF_3 = 4'd4,
        REG_COEFF_4 = 4'd5,
        REG_COEFF_5 = 4'd6,
        REG_COEFF_6 = 4'd7
    } reg_idx_t;

    // one item between horner steps
    typedef struct packed {
        logic              valid;
        logic              ovf;
        logic [DATA_W-1:0] acc;
        logic [DATA_W-1:0] x;
    } stage_t;

endpackage

`default_nettype wire

### hdl/pe_regs.sv
// configuration registers: degree and coefficients, degree clamp and step enables
// depends on pe_pkg
`default_nettype none

module pe_regs #(
    parameter int MAX_DEGREE = pe_pkg::DEF_MAX_DEGREE,
    localparam int LIM = (MAX_DEGREE < pe_pkg::NUM_COEFFS - 1) ? MAX_DEGREE
                                                                : pe_pkg::NUM_COEFFS - 1
) (
    input  wire logic                                     clk,
    input  wire logic                                     rst_n,
    input  wire logic                                     wr_en,
    input  wire logic [pe_pkg::IDX_W-1:0]                 wr_index,
    input  wire logic [pe_pkg::DATA_W-1:0]                wr_data,
    output logic [pe_pkg::NUM_COEFFS-1:0][pe_pkg::DATA_W-1:0] coeff,
    output logic [pe_pkg::DATA_W-1:0]                     head_coeff,
    output logic [LIM-1:0]                                active
);

    logic [pe_pkg::DEG_W-1:0]                              degree_reg;
    logic [pe_pkg::NUM_COEFFS-1:0][pe_pkg::DATA_W-1:0]     coeff_reg;
    logic [pe_pkg::DEG_W-1:0]                              n_eff;
    logic [pe_pkg::IDX_W-1:0]                              coeff_sel;

    assign coeff_sel = wr_index - pe_pkg::REG_COEFF_0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            degree_reg <= '0;
            coeff_reg  <= '0;
        end
        else if (wr_en)
        begin
            case (wr_index)
                pe_pkg::REG_DEGREE:
                begin
                    degree_reg <= wr_data[pe_pkg::DEG_W-1:0];
                end
                default:
                begin
                    // writes to unknown indexes are dropped
                    if (wr_index inside {[pe_pkg::REG_COEFF_0:pe_pkg::REG_COEFF_6]})
                    begin
                        coeff_reg[coeff_sel[pe_pkg::DEG_W-1:0]] <= wr_data;
                    end
                end
            endcase
        end
    end

    always_comb
    begin
        n_eff = (degree_reg > pe_pkg::DEG_W'(LIM)) ? pe_pkg::DEG_W'(LIM) : degree_reg;
        for (int k = 0; k < LIM; k++)
        begin
            active[k] = (pe_pkg::DEG_W'(k) < n_eff);
        end
    end

    assign coeff      = coeff_reg;
    assign head_coeff = coeff_reg[n_eff];

endmodule

`default_nettype wire

### hdl/pe_step.sv
// one horner step in three stages: multiply, round, add coefficient and saturate
// depends on pe_pkg
`default_nettype none

module pe_step #(
    parameter int FRAC_BITS = pe_pkg::DEF_FRAC_BITS
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire pe_pkg::stage_t                s_in,
    input  wire logic [pe_pkg::DATA_W-1:0]     coeff,
    input  wire logic                          active,
    output pe_pkg::stage_t                     s_out
);

    localparam int PW = pe_pkg::PROD_W;
    localparam int DW = pe_pkg::DATA_W;
    localparam int SW = PW + 1;
    localparam logic signed [PW-1:0] HALF =
        (FRAC_BITS > 0) ? (PW'(1) << ((FRAC_BITS > 0) ? FRAC_BITS - 1 : 0)) : '0;

    // stage 1
    logic                 valid_1_reg;
    logic                 ovf_1_reg;
    logic [DW-1:0]        acc_1_reg;
    logic [DW-1:0]        x_1_reg;
    logic signed [PW-1:0] prod_1_reg;
    logic signed [PW-1:0] prod_next;

    // stage 2
    logic                 valid_2_reg;
    logic                 ovf_2_reg;
    logic [DW-1:0]        acc_2_reg;
    logic [DW-1:0]        x_2_reg;
    logic signed [PW-1:0] rnd_2_reg;
    logic signed [PW-1:0] rnd_next;

    // stage 3
    logic                 valid_3_reg;
    logic                 ovf_3_reg;
    logic [DW-1:0]        acc_3_reg;
    logic [DW-1:0]        x_3_reg;
    logic [SW-1:0]        sum;
    logic                 sat_hi;
    logic                 sat_lo;
    logic                 ovf_next;
    logic [DW-1:0]        acc_next;

    assign prod_next = $signed(s_in.acc) * $signed(s_in.x);
    // floor after adding half an lsb: halves go toward plus infinity
    assign rnd_next  = (prod_1_reg + HALF) >>> FRAC_BITS;

    always_comb
    begin
        sum    = {rnd_2_reg[PW-1], rnd_2_reg} + {{(SW-DW){coeff[DW-1]}}, coeff};
        sat_hi = !sum[SW-1] && (|sum[SW-2:DW-1]);
        sat_lo = sum[SW-1] && !(&sum[SW-2:DW-1]);
        if (active)
        begin
            ovf_next = ovf_2_reg | sat_hi | sat_lo;
            if (sat_hi)
            begin
                acc_next = pe_pkg::S32_MAX;
            end
            else if (sat_lo)
            begin
                acc_next = pe_pkg::S32_MIN;
            end
            else
            begin
                acc_next = sum[DW-1:0];
            end
        end
        else
        begin
            // coefficient at or above the degree: pass the accumulator through
            ovf_next = ovf_2_reg;
            acc_next = acc_2_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_1_reg <= 1'b0;
            valid_2_reg <= 1'b0;
            valid_3_reg <= 1'b0;
        end
        else
        begin
            valid_1_reg <= s_in.valid;
            valid_2_reg <= valid_1_reg;
            valid_3_reg <= valid_2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        ovf_1_reg  <= s_in.ovf;
        acc_1_reg  <= s_in.acc;
        x_1_reg    <= s_in.x;
        prod_1_reg <= prod_next;

        ovf_2_reg  <= ovf_1_reg;
        acc_2_reg  <= acc_1_reg;
        x_2_reg    <= x_1_reg;
        rnd_2_reg  <= rnd_next;

        ovf_3_reg  <= ovf_next;
        acc_3_reg  <= acc_next;
        x_3_reg    <= x_2_reg;
    end

    assign s_out.valid = valid_3_reg;
    assign s_out.ovf   = ovf_3_reg;
    assign s_out.acc   = acc_3_reg;
    assign s_out.x     = x_3_reg;

    a_valid_travels: assert property (@(posedge clk) disable iff (!rst_n)
        s_out.valid |-> $past(s_in.valid, 3))
        else $error("step output valid without an item three cycles earlier");

    a_ovf_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        s_out.valid |-> (s_out.ovf || !$past(s_in.ovf, 3)))
        else $error("overflow flag cleared inside a step");

    a_new_ovf_saturates: assert property (@(posedge clk) disable iff (!rst_n)
        (s_out.valid && s_out.ovf && !$past(s_in.ovf, 3)) |->
        (s_out.acc == pe_pkg::S32_MAX || s_out.acc == pe_pkg::S32_MIN))
        else $error("step raised overflow without a saturated result");

endmodule

`default_nettype wire

### hdl/polynomial_evaluator.sv
// top level of the pipelined horner polynomial evaluator
// depends on pe_pkg, pe_regs and pe_step
//
// usage:
//   samples enter on sample_x when start is high and busy is low. busy is
//   high only during reset and the first cycle after it, so a sample may be
//   given in every cycle after that.
//   each result appears on value_y and overflow for one cycle with done high.
//   each sample is registered at the input and then passes through LIM horner
//   steps, with LIM the smaller of MAX_DEGREE and 6.
//   every horner step is one multiply stage, one rounding stage and one
//   add-and-saturate stage; all LIM steps are always present, and steps above
//   the programmed degree pass the accumulator through unchanged.
//   throughput is one sample per cycle while busy is low, whatever the degree.
//   configuration: cfg_index 0 is the degree, 1 to 7 the coefficients c0..c6;
//   other indexes are ignored. write only while no sample is in flight.
//   reset clears the degree and all coefficients and empties the pipeline.
//   the receiver cannot stall; results leave in sample order.
`default_nettype none

module polynomial_evaluator #(
    parameter int MAX_DEGREE = pe_pkg::DEF_MAX_DEGREE,
    parameter int FRAC_BITS  = pe_pkg::DEF_FRAC_BITS
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              start,
    output logic                                   busy,
    input  wire logic signed [pe_pkg::DATA_W-1:0]  sample_x,
    output logic                                   done,
    output logic signed [pe_pkg::DATA_W-1:0]       value_y,
    output logic                                   overflow,
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [pe_pkg::IDX_W-1:0]          cfg_index,
    input  wire logic [pe_pkg::DATA_W-1:0]         cfg_data
);

    localparam int LIM = (MAX_DEGREE < pe_pkg::NUM_COEFFS - 1) ? MAX_DEGREE
                                                                : pe_pkg::NUM_COEFFS - 1;
    localparam int LAT = 3 * LIM + 1;

    logic                                              ready_reg;
    logic                                              in_valid_reg;
    logic [pe_pkg::DATA_W-1:0]                         in_x_reg;
    logic [pe_pkg::DATA_W-1:0]                         in_acc_reg;
    logic                                              accept;
    logic [pe_pkg::NUM_COEFFS-1:0][pe_pkg::DATA_W-1:0] coeff;
    logic [pe_pkg::DATA_W-1:0]                         head_coeff;
    logic [LIM-1:0]                                    active;
    pe_pkg::stage_t                                    chain [LIM+1];

    assign accept    = start && !busy;
    assign busy      = !ready_reg;
    assign cfg_ready = ready_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ready_reg    <= 1'b0;
            in_valid_reg <= 1'b0;
        end
        else
        begin
            ready_reg    <= 1'b1;
            in_valid_reg <= accept;
        end
    end

    // horner starts from the coefficient at the programmed degree, clamped to LIM
    always_ff @(posedge clk)
    begin
        in_x_reg   <= sample_x;
        in_acc_reg <= head_coeff;
    end

    pe_regs #(
        .MAX_DEGREE (MAX_DEGREE)
    ) u_regs (
        .clk        (clk),
        .rst_n      (rst_n),
        .wr_en      (cfg_valid && cfg_ready),
        .wr_index   (cfg_index),
        .wr_data    (cfg_data),
        .coeff      (coeff),
        .head_coeff (head_coeff),
        .active     (active)
    );

    assign chain[0].valid = in_valid_reg;
    assign chain[0].ovf   = 1'b0;
    assign chain[0].acc   = in_acc_reg;
    assign chain[0].x     = in_x_reg;

    for (genvar j = 0; j < LIM; j++)
    begin : g_step
        pe_step #(
            .FRAC_BITS (FRAC_BITS)
        ) u_step (
            .clk    (clk),
            .rst_n  (rst_n),
            .s_in   (chain[j]),
            .coeff  (coeff[LIM-1-j]),
            .active (active[LIM-1-j]),
            .s_out  (chain[j+1])
        );
    end

    assign done     = chain[LIM].valid;
    assign value_y  = chain[LIM].acc;
    assign overflow = chain[LIM].ovf;

    a_fixed_latency: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> ##LAT done)
        else $error("result did not arrive after the pipeline latency");

    a_no_result_out_of_reset: assert property (@(posedge clk) disable iff (!rst_n)
        !cfg_ready |-> !done)
        else $error("result strobe right after reset");

    a_result_known: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !$isunknown({value_y, overflow}))
        else $error("result strobe with an unknown value");

endmodule

`default_nettype wire
